@@ hdl/smc_pkg.sv @@
// ----------------------------------------------------------------------------
// smc_pkg: shared constants and types for the symbol match counter
// Field widths, store depths, command and register codes used by all stages.
// ----------------------------------------------------------------------------
package smc_pkg;

    // store depths
    localparam int MAX_PATTERN = 64;
    localparam int MAX_TEXT    = 65536;

    // field widths
    localparam int CHAR_W   = 8;
    localparam int IDX_W    = 6;
    localparam int LEN_W    = 7;
    localparam int ALIGN_W  = 16;
    localparam int COUNT_W  = 7;
    localparam int CMD_W    = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;

    // stream data widths, padded to whole bytes
    localparam int IN_DATA_W  = ((CHAR_W + IDX_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((ALIGN_W + COUNT_W + 7) / 8) * 8;

    // derived widths
    localparam int PIDX_W     = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int SEEN_W     = $clog2(MAX_TEXT + 1);
    localparam int SH_W       = $clog2(MAX_PATTERN + 1);
    localparam int GROUP_SIZE = 8;
    localparam int NUM_GROUPS = (MAX_PATTERN + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PAD_LEN    = NUM_GROUPS * GROUP_SIZE;
    localparam int GRP_CNT_W  = $clog2(GROUP_SIZE + 1);
    localparam int CNT_FULL_W = $clog2(MAX_PATTERN + 1);
    localparam int SUM_W      = (CNT_FULL_W > COUNT_W) ? CNT_FULL_W : COUNT_W;
    localparam int COUNT_MAX  = (1 << COUNT_W) - 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_SYMBOL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 1'b1;

    // request commands
    typedef enum logic [CMD_W-1:0] {
        CMD_PATTERN = 2'd0,
        CMD_TEXT    = 2'd1,
        CMD_START   = 2'd2
    } cmd_t;

    // per-group partial popcounts
    typedef logic [NUM_GROUPS-1:0][GRP_CNT_W-1:0] grp_cnt_t;

    // state seen by the alignment stage
    typedef struct packed {
        logic              pend;
        logic [SEEN_W-1:0] seen;
        logic [LEN_W-1:0]  len;
    } state_view_t;

endpackage

@@ hdl/smc_state.sv @@
// ----------------------------------------------------------------------------
// smc_state: configuration, pattern store, text hit window and position
// Applies each accepted request to the state and flags a pending result.
// ----------------------------------------------------------------------------
module smc_state
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [smc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [smc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    input  logic [smc_pkg::CMD_W-1:0]       in_cmd,
    input  logic [smc_pkg::CHAR_W-1:0]      in_char,
    input  logic [smc_pkg::IDX_W-1:0]       in_index,
    input  logic                            grp_free,
    output logic                            in_ready,
    output logic [smc_pkg::MAX_PATTERN-1:0] window,
    output logic [smc_pkg::MAX_PATTERN-1:0] pat_hit,
    output smc_pkg::state_view_t            view
);
    import smc_pkg::*;

    logic [CHAR_W-1:0]      symbol_reg, symbol_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [MAX_PATTERN-1:0] window_reg, window_next;
    logic [SEEN_W-1:0]      seen_reg, seen_next;
    logic                   pend_reg, pend_next;
    logic [CHAR_W-1:0]      pattern_reg [MAX_PATTERN];
    logic [LEN_W-1:0]       eff_len;
    logic                   accept;
    logic                   pat_we;
    cmd_t                   cmd;

    assign cmd      = cmd_t'(in_cmd);
    assign in_ready = !pend_reg || grp_free;
    assign accept   = in_valid && in_ready;
    assign pat_we   = accept && (cmd == CMD_PATTERN) && (int'(in_index) < MAX_PATTERN);

    // effective pattern length, clamped to 1..MAX_PATTERN
    always_comb
    begin
        if (len_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (int'(len_reg) > MAX_PATTERN)
        begin
            eff_len = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            eff_len = len_reg;
        end
    end

    // configuration writes
    always_comb
    begin
        symbol_next = symbol_reg;
        len_next    = len_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MATCH_SYMBOL: symbol_next = cfg_data;
                CFG_PATTERN_LEN:  len_next    = cfg_data[LEN_W-1:0];
                default:          symbol_next = symbol_reg;
            endcase
        end
    end

    // window, position and pending result
    always_comb
    begin
        window_next = window_reg;
        seen_next   = seen_reg;
        pend_next   = pend_reg;
        if (in_ready)
        begin
            pend_next = 1'b0;
        end
        if (accept)
        begin
            case (cmd)
                CMD_TEXT:
                begin
                    window_next = (window_reg << 1) |
                                  MAX_PATTERN'(in_char == symbol_reg);
                    if (int'(seen_reg) < MAX_TEXT)
                    begin
                        seen_next = seen_reg + SEEN_W'(1);
                    end
                    pend_next = (seen_next >= SEEN_W'(eff_len));
                end
                CMD_START:
                begin
                    window_next = '0;
                    seen_next   = '0;
                end
                default:
                begin
                    window_next = window_reg;
                end
            endcase
        end
    end

    // control and window registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_reg <= '0;
            len_reg    <= LEN_W'(1);
            window_reg <= '0;
            seen_reg   <= '0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            symbol_reg <= symbol_next;
            len_reg    <= len_next;
            window_reg <= window_next;
            seen_reg   <= seen_next;
            pend_reg   <= pend_next;
        end
    end

    // pattern store, undefined until written
    always_ff @(posedge clk)
    begin
        if (pat_we)
        begin
            pattern_reg[PIDX_W'(in_index)] <= in_char;
        end
    end

    // one compare lane per pattern position
    always_comb
    begin
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            pat_hit[j] = (pattern_reg[j] == symbol_reg);
        end
    end

    assign window    = window_reg;
    assign view.pend = pend_reg;
    assign view.seen = seen_reg;
    assign view.len  = eff_len;

endmodule

@@ hdl/smc_align.sv @@
// ----------------------------------------------------------------------------
// smc_align: lines the window up with the pattern and counts per group
// Reverses the hit window and shifts it by MAX_PATTERN less the pattern
// length, ANDs it with the pattern hits, registers a small popcount per group.
// ----------------------------------------------------------------------------
module smc_align
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  smc_pkg::state_view_t            view,
    input  logic [smc_pkg::MAX_PATTERN-1:0] window,
    input  logic [smc_pkg::MAX_PATTERN-1:0] pat_hit,
    input  logic                            out_free,
    output logic                            grp_valid,
    output logic                            grp_free,
    output smc_pkg::grp_cnt_t               grp_cnt,
    output logic [smc_pkg::ALIGN_W-1:0]     grp_align
);
    import smc_pkg::*;

    logic                   valid_reg, valid_next;
    grp_cnt_t               cnt_reg, cnt_next;
    logic [ALIGN_W-1:0]     align_reg, align_next;
    logic [MAX_PATTERN-1:0] rev;
    logic [MAX_PATTERN-1:0] aligned;
    logic [PAD_LEN-1:0]     coinc;
    logic [SH_W-1:0]        shift;
    logic [SEEN_W-1:0]      start;
    logic                   load;

    assign grp_free = !valid_reg || out_free;
    assign load     = view.pend && grp_free;

    // oldest hit of the alignment lands on pattern position 0
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            rev[i] = window[MAX_PATTERN - 1 - i];
        end
    end

    assign shift   = SH_W'(MAX_PATTERN) - SH_W'(view.len);
    assign aligned = rev >> shift;
    assign coinc   = PAD_LEN'(aligned & pat_hit);
    assign start   = view.seen - SEEN_W'(view.len);

    // group popcounts
    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            cnt_next[g] = '0;
            for (int b = 0; b < GROUP_SIZE; b++)
            begin
                cnt_next[g] = cnt_next[g] + GRP_CNT_W'(coinc[g * GROUP_SIZE + b]);
            end
        end
    end

    assign align_next = start[ALIGN_W-1:0];

    // stage valid
    always_comb
    begin
        valid_next = valid_reg;
        if (grp_free)
        begin
            valid_next = view.pend;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cnt_reg   <= cnt_next;
            align_reg <= align_next;
        end
    end

    assign grp_valid = valid_reg;
    assign grp_cnt   = cnt_reg;
    assign grp_align = align_reg;

endmodule

@@ hdl/smc_sum.sv @@
// ----------------------------------------------------------------------------
// smc_sum: adds the group counts and holds the result for the output
// Saturating sum of the partial popcounts into the output register.
// ----------------------------------------------------------------------------
module smc_sum
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          grp_valid,
    input  smc_pkg::grp_cnt_t             grp_cnt,
    input  logic [smc_pkg::ALIGN_W-1:0]   grp_align,
    input  logic                          out_ready,
    output logic                          out_free,
    output logic                          out_valid,
    output logic [smc_pkg::ALIGN_W-1:0]   out_align,
    output logic [smc_pkg::COUNT_W-1:0]   out_count
);
    import smc_pkg::*;

    logic               valid_reg, valid_next;
    logic [ALIGN_W-1:0] align_reg;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0]   total;
    logic               load;

    assign out_free = !valid_reg || out_ready;
    assign load     = grp_valid && out_free;

    // sum of group counts
    always_comb
    begin
        total = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            total = total + SUM_W'(grp_cnt[g]);
        end
    end

    // saturate to the field
    always_comb
    begin
        if (total > SUM_W'(COUNT_MAX))
        begin
            count_next = COUNT_W'(COUNT_MAX);
        end
        else
        begin
            count_next = total[COUNT_W-1:0];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (out_free)
        begin
            valid_next = grp_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            align_reg <= grp_align;
            count_reg <= count_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_align = align_reg;
    assign out_count = count_reg;

endmodule

@@ hdl/symbol_match_count_per_alignment_unit.sv @@
// A text request accepted updates the state registers; its result then passes
//   the alignment and group count registers and the final sum register to m_tvalid.
// Throughput: one request per cycle while no stage stalls; the window AND and group
//   popcount stage and the sum stage are each registered, with backpressure through all three.
// Reset clears the hit window, position, pending flags, match_symbol to 0 and
//   pattern_len to 1; the pattern store is not reset and is valid once written.
// ----------------------------------------------------------------------------
// symbol_match_count_per_alignment_unit: per-alignment symbol match counter
// Counts positions where text and pattern both equal the configured symbol.
// ----------------------------------------------------------------------------
module symbol_match_count_per_alignment_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [smc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [smc_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [smc_pkg::IN_DATA_W-1:0]   s_tdata,   // char_value[7:0], pattern_index[13:8]
    input  logic [smc_pkg::CMD_W-1:0]       s_tuser,   // cmd[1:0]
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [smc_pkg::OUT_DATA_W-1:0]  m_tdata    // alignment[15:0], match_count[22:16]
);
    import smc_pkg::*;

    logic [MAX_PATTERN-1:0] window;
    logic [MAX_PATTERN-1:0] pat_hit;
    state_view_t            view;
    logic                   grp_valid;
    logic                   grp_free;
    grp_cnt_t               grp_cnt;
    logic [ALIGN_W-1:0]     grp_align;
    logic                   out_free;
    logic [ALIGN_W-1:0]     out_align;
    logic [COUNT_W-1:0]     out_count;

    assign cfg_ready = 1'b1;

    // state and request decode
    smc_state u_state
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_cmd    (s_tuser),
        .in_char   (s_tdata[CHAR_W-1:0]),
        .in_index  (s_tdata[CHAR_W +: IDX_W]),
        .grp_free  (grp_free),
        .in_ready  (s_tready),
        .window    (window),
        .pat_hit   (pat_hit),
        .view      (view)
    );

    // alignment and group counts
    smc_align u_align
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .view      (view),
        .window    (window),
        .pat_hit   (pat_hit),
        .out_free  (out_free),
        .grp_valid (grp_valid),
        .grp_free  (grp_free),
        .grp_cnt   (grp_cnt),
        .grp_align (grp_align)
    );

    // final sum and output register
    smc_sum u_sum
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp_valid (grp_valid),
        .grp_cnt   (grp_cnt),
        .grp_align (grp_align),
        .out_ready (m_tready),
        .out_free  (out_free),
        .out_valid (m_tvalid),
        .out_align (out_align),
        .out_count (out_count)
    );

    assign m_tdata = OUT_DATA_W'({out_count, out_align});

    // a count never exceeds the pattern length in force
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (SUM_W'(out_count) <= SUM_W'(view.len)))
        else $error("match count above pattern length");

    // with the pipeline empty the input side is open
    assert property (@(posedge clk) disable iff (!rst_n)
        (!view.pend && !grp_valid && !m_tvalid) |-> s_tready)
        else $error("input stalled with empty pipeline");

    // a pending result that cannot move keeps the state frozen
    assert property (@(posedge clk) disable iff (!rst_n)
        (view.pend && !grp_free) |=> (view.pend && $stable(view.seen) && $stable(window)))
        else $error("state changed under a stalled result");

endmodule
